// ----- sv/khegp_pkg.sv -----
// shared constants, types and range tables of the keyed hash edge gate
package khegp_pkg;

  localparam int PROB_FRAC_BITS = 32;
  localparam int PROB_W         = PROB_FRAC_BITS + 1;
  localparam int MAX_FACTORS    = 5;
  localparam int KEY_W          = 64;
  localparam int DEG_W          = 32;
  localparam int FACT_W         = 3;
  localparam int HASH_W         = 64;
  localparam int U_W            = 53;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 64;

  localparam logic [HASH_W-1:0] MIX_GOLD = 64'h9e3779b97f4a7c15;
  localparam logic [HASH_W-1:0] MIX_M1   = 64'hbf58476d1ce4e5b9;
  localparam logic [HASH_W-1:0] MIX_M2   = 64'h94d049bb133111eb;
  localparam logic [HASH_W-1:0] SEED_XOR = 64'h243f6a8885a308d3;

  localparam logic [CFG_IDX_W-1:0] CFG_GATED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 2'd2;

  // range ends in hundredths, rounded half up to fixed point
  localparam logic [PROB_FRAC_BITS-1:0] FX_02 =
    PROB_FRAC_BITS'(((64'd2 << PROB_FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [PROB_FRAC_BITS-1:0] FX_05 =
    PROB_FRAC_BITS'(((64'd5 << PROB_FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [PROB_FRAC_BITS-1:0] FX_10 =
    PROB_FRAC_BITS'(((64'd10 << PROB_FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [PROB_FRAC_BITS-1:0] FX_12 =
    PROB_FRAC_BITS'(((64'd12 << PROB_FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [PROB_FRAC_BITS-1:0] FX_15 =
    PROB_FRAC_BITS'(((64'd15 << PROB_FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [PROB_FRAC_BITS-1:0] FX_18 =
    PROB_FRAC_BITS'(((64'd18 << PROB_FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [PROB_FRAC_BITS-1:0] FX_22 =
    PROB_FRAC_BITS'(((64'd22 << PROB_FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [PROB_FRAC_BITS-1:0] FX_30 =
    PROB_FRAC_BITS'(((64'd30 << PROB_FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [PROB_FRAC_BITS-1:0] FX_35 =
    PROB_FRAC_BITS'(((64'd35 << PROB_FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [PROB_FRAC_BITS-1:0] FX_45 =
    PROB_FRAC_BITS'(((64'd45 << PROB_FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [PROB_FRAC_BITS-1:0] FX_55 =
    PROB_FRAC_BITS'(((64'd55 << PROB_FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [PROB_FRAC_BITS-1:0] FX_90 =
    PROB_FRAC_BITS'(((64'd90 << PROB_FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [PROB_FRAC_BITS-1:0] FX_95 =
    PROB_FRAC_BITS'(((64'd95 << PROB_FRAC_BITS) + 64'd50) / 64'd100);

  typedef struct packed {
    logic [KEY_W-1:0]  src;
    logic [KEY_W-1:0]  dst;
    logic [DEG_W-1:0]  deg;
    logic [FACT_W-1:0] factor;
    logic [FACT_W-1:0] count;
    logic              last;
    logic              gated;
  } tag_t;

  function automatic logic [PROB_FRAC_BITS-1:0] gate_lo(input logic [FACT_W-1:0] count,
                                                         input logic [FACT_W-1:0] f);
    logic [PROB_FRAC_BITS-1:0] r;
    if (count == FACT_W'(2)) begin
      r = (f == FACT_W'(1)) ? FX_10 : FX_55;
    end else if (count == FACT_W'(3)) begin
      case (f)
        FACT_W'(1): r = FX_05;
        FACT_W'(2): r = FX_35;
        default:    r = FX_15;
      endcase
    end else begin
      case (f)
        FACT_W'(2): r = FX_45;
        FACT_W'(3): r = FX_12;
        FACT_W'(4): r = FX_05;
        default:    r = FX_02;
      endcase
    end
    return r;
  endfunction

  function automatic logic [PROB_FRAC_BITS-1:0] gate_hi(input logic [FACT_W-1:0] count,
                                                         input logic [FACT_W-1:0] f);
    logic [PROB_FRAC_BITS-1:0] r;
    if (count == FACT_W'(2)) begin
      r = (f == FACT_W'(1)) ? FX_45 : FX_95;
    end else if (count == FACT_W'(3)) begin
      case (f)
        FACT_W'(1): r = FX_30;
        FACT_W'(2): r = FX_90;
        default:    r = FX_55;
      endcase
    end else begin
      case (f)
        FACT_W'(2): r = FX_95;
        FACT_W'(3): r = FX_45;
        FACT_W'(4): r = FX_22;
        default:    r = FX_18;
      endcase
    end
    return r;
  endfunction

endpackage

// ----- sv/khegp_mix.sv -----
// one splitmix64 round as a five-stage pipeline
module khegp_mix
  import khegp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [HASH_W-1:0] in_v,
  input  tag_t              in_tag,
  output logic              out_valid,
  output logic [HASH_W-1:0] out_v,
  output tag_t              out_tag
);

  logic [4:0]        vld;
  tag_t              tag [0:4];
  logic [HASH_W-1:0] t1, t2, y, z, a;
  logic [63:0]       ll1, ll2;
  logic [31:0]       lh1, hl1, lh2, hl2;

  assign a = in_v + MIX_GOLD;
  assign y = ll1 + {lh1 + hl1, 32'b0};
  assign z = ll2 + {lh2 + hl2, 32'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // add and first xor shift
      t1     <= a ^ (a >> 30);
      tag[0] <= in_tag;
      // partial products by the first constant
      ll1    <= 64'(t1[31:0]) * 64'(MIX_M1[31:0]);
      lh1    <= 32'(t1[31:0] * MIX_M1[63:32]);
      hl1    <= 32'(t1[63:32] * MIX_M1[31:0]);
      tag[1] <= tag[0];
      t2     <= y ^ (y >> 27);
      tag[2] <= tag[1];
      // partial products by the second constant
      ll2    <= 64'(t2[31:0]) * 64'(MIX_M2[31:0]);
      lh2    <= 32'(t2[31:0] * MIX_M2[63:32]);
      hl2    <= 32'(t2[63:32] * MIX_M2[31:0]);
      tag[3] <= tag[2];
      out_v  <= z ^ (z >> 31);
      tag[4] <= tag[3];
    end
  end

  assign out_valid = vld[4];
  assign out_tag   = tag[4];

endmodule

// ----- sv/khegp_gate.sv -----
// range lookup and hash scaling into the dividend of the probability
module khegp_gate
  import khegp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [HASH_W-1:0] in_hash,
  input  tag_t              in_tag,
  output logic              out_valid,
  output logic [PROB_W-1:0] out_num,
  output tag_t              out_tag
);

  logic [2:0]                vld;
  tag_t                      tag [0:2];
  logic [PROB_FRAC_BITS-1:0] lo0, diff0, lo1;
  logic [U_W-1:0]            u0;
  logic [63:0]               pa;
  logic [52:0]               pb;
  logic [84:0]               sum;
  logic [PROB_FRAC_BITS-1:0] scaled;

  assign sum    = {21'b0, pa} + {pb, 32'b0};
  assign scaled = sum[84:53];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo0     <= gate_lo(in_tag.count, in_tag.factor);
      diff0   <= gate_hi(in_tag.count, in_tag.factor) - gate_lo(in_tag.count, in_tag.factor);
      u0      <= in_hash[HASH_W-1 -: U_W];
      tag[0]  <= in_tag;
      pa      <= 64'(diff0) * 64'(u0[31:0]);
      pb      <= 53'(diff0) * 53'(u0[52:32]);
      lo1     <= lo0;
      tag[1]  <= tag[0];
      out_num <= tag[1].gated ? PROB_W'(lo1) + PROB_W'(scaled)
                              : PROB_W'(1) << PROB_FRAC_BITS;
      tag[2]  <= tag[1];
    end
  end

  assign out_valid = vld[2];
  assign out_tag   = tag[2];

endmodule

// ----- sv/khegp_div.sv -----
// restoring divider, one quotient bit per pipeline stage
module khegp_div
  import khegp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [PROB_W-1:0] in_num,
  input  tag_t              in_tag,
  output logic              out_valid,
  output logic [PROB_W-1:0] out_quo,
  output tag_t              out_tag
);

  logic [PROB_W:0]      vld;
  tag_t                 tag [0:PROB_W];
  logic [DEG_W-1:0]     rem [0:PROB_W];
  logic [PROB_W-1:0]    num [0:PROB_W];
  logic [PROB_W-1:0]    quo [0:PROB_W];

  assign vld[0] = in_valid;
  assign tag[0] = in_tag;
  assign rem[0] = '0;
  assign num[0] = in_num;
  assign quo[0] = '0;

  for (genvar k = 0; k < PROB_W; k++) begin : g_stage
    logic [DEG_W:0] trial;
    logic           ge;
    assign trial = {rem[k], num[k][PROB_W-1]};
    assign ge    = trial >= {1'b0, tag[k].deg};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? DEG_W'(trial - {1'b0, tag[k].deg}) : DEG_W'(trial);
        num[k+1] <= num[k] << 1;
        quo[k+1] <= {quo[k][PROB_W-2:0], ge};
        tag[k+1] <= tag[k];
      end
    end
  end

  assign out_valid = vld[PROB_W];
  assign out_quo   = quo[PROB_W];
  assign out_tag   = tag[PROB_W];

endmodule

// ----- sv/keyed_hash_edge_gate_probability.sv -----
// top level: edge intake, factor sequencer, hash, gate and divide pipeline
// Takes one edge per request and issues one factor result per cycle while the
// pipeline is not held: an edge with N factors (N is factor_count, capped at
// five) holds the intake until its last factor issues, when the next edge can
// be taken; an edge with zero in-degree or a zero count gives nothing. Each
// factor then runs through a fixed pipeline of four five-stage splitmix
// rounds, three gate stages, a one-bit-per-stage divider of 33 stages and
// the output register. The whole pipeline holds while the output register is
// full and not taken. Configuration is written on its own channel and always
// accepted; index 0 gated_mode, 1 factor_count, 2 hash_seed, others ignored.
module keyed_hash_edge_gate_probability
  import khegp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [159:0]          s_tdata,   // source_key, dest_key, in_degree
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [39:0]           m_tdata,   // factor_number, probability, zero pad
  output logic                  m_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic              gated_mode;
  logic [FACT_W-1:0] factor_count;
  logic [HASH_W-1:0] hash_seed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gated_mode   <= 1'b0;
      factor_count <= FACT_W'(2);
      hash_seed    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GATED: gated_mode   <= cfg_data[0];
        CFG_COUNT: factor_count <= cfg_data[FACT_W-1:0];
        CFG_SEED:  hash_seed    <= cfg_data;
        default:   ;
      endcase
    end
  end

  // global advance: the pipeline moves whenever the output register can load
  logic en;
  logic m_valid_r;
  assign en = !m_valid_r || m_tready;

  // factor sequencer holds the current edge
  logic              busy;
  logic [FACT_W-1:0] fact, cnt;
  logic [KEY_W-1:0]  src, dst;
  logic [DEG_W-1:0]  deg;
  logic              issue_last, accept;
  logic [FACT_W-1:0] cnt_sat;
  logic [DEG_W-1:0]  in_deg;

  assign in_deg     = s_tdata[159:128];
  assign cnt_sat    = (factor_count > FACT_W'(MAX_FACTORS)) ? FACT_W'(MAX_FACTORS)
                                                           : factor_count;
  assign issue_last = busy && (fact == cnt);
  assign s_tready   = en && (!busy || issue_last);
  assign accept     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fact <= '0;
    end else if (accept) begin
      // zero in-degree or zero count: the edge is dropped
      busy <= (in_deg != '0) && (cnt_sat != '0);
      fact <= FACT_W'(1);
    end else if (en && busy) begin
      busy <= !issue_last;
      fact <= fact + FACT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      src <= s_tdata[63:0];
      dst <= s_tdata[127:64];
      deg <= in_deg;
      cnt <= cnt_sat;
    end
  end

  tag_t issue_tag;
  always_comb begin
    issue_tag.src    = src;
    issue_tag.dst    = dst;
    issue_tag.deg    = deg;
    issue_tag.factor = fact;
    issue_tag.count  = cnt;
    issue_tag.last   = (fact == cnt);
    issue_tag.gated  = gated_mode;
  end

  // four chained rounds: seed, source, destination, factor
  logic              r_valid [0:4];
  logic [HASH_W-1:0] r_hash  [0:4];
  tag_t              r_tag   [0:4];
  logic [HASH_W-1:0] r_in    [0:3];

  assign r_valid[0] = busy;
  assign r_hash[0]  = '0;
  assign r_tag[0]   = issue_tag;

  assign r_in[0] = hash_seed ^ SEED_XOR;
  assign r_in[1] = r_hash[1] ^ r_tag[1].src;
  assign r_in[2] = r_hash[2] ^ r_tag[2].dst;
  assign r_in[3] = r_hash[3] ^ HASH_W'(r_tag[3].factor);

  for (genvar r = 0; r < 4; r++) begin : g_round
    khegp_mix u_mix (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (r_valid[r]),
      .in_v      (r_in[r]),
      .in_tag    (r_tag[r]),
      .out_valid (r_valid[r+1]),
      .out_v     (r_hash[r+1]),
      .out_tag   (r_tag[r+1])
    );
  end

  logic              g_valid;
  logic [PROB_W-1:0] g_num;
  tag_t              g_tag;

  khegp_gate u_gate (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (r_valid[4]),
    .in_hash   (r_hash[4]),
    .in_tag    (r_tag[4]),
    .out_valid (g_valid),
    .out_num   (g_num),
    .out_tag   (g_tag)
  );

  logic              d_valid;
  logic [PROB_W-1:0] d_quo;
  tag_t              d_tag;

  khegp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (g_valid),
    .in_num    (g_num),
    .in_tag    (g_tag),
    .out_valid (d_valid),
    .out_quo   (d_quo),
    .out_tag   (d_tag)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid_r <= 1'b0;
    end else if (en) begin
      m_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {4'b0, d_quo, d_tag.factor};
      m_tlast <= d_tag.last;
    end
  end

  assign m_tvalid = m_valid_r;

  // a delivered result always names a real factor
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] != '0)
    else $error("result with factor number zero");

  // the sequencer never runs past the edge's factor count
  assert property (@(posedge clk) disable iff (rst)
    busy |-> (fact != '0) && (fact <= cnt))
    else $error("factor counter out of range");

  // an edge with zero in-degree leaves the sequencer idle
  assert property (@(posedge clk) disable iff (rst)
    accept && (in_deg == '0) |=> !busy)
    else $error("zero in-degree edge issued factors");

  // the sequencer holds its factor while the pipeline is stalled
  assert property (@(posedge clk) disable iff (rst)
    busy && !en |=> $stable(fact) && busy)
    else $error("factor advanced during stall");

endmodule

// ----- tb/sv/khegp_checker.sv -----
// request monitor, factor probability predictor and result scoreboard
`timescale 1ns / 1ps
module khegp_checker
  import khegp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [159:0]          s_tdata,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [39:0]           m_tdata,
  input  logic                  m_tlast,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);

  typedef struct {
    logic [FACT_W-1:0] factor;
    logic [PROB_W-1:0] prob;
    logic              last;
  } factor_prob_t;

  factor_prob_t      prob_queue[$];
  logic              gated_q;
  logic [FACT_W-1:0] count_q;
  logic [HASH_W-1:0] seed_q;

  function automatic logic [63:0] splitmix(input logic [63:0] v);
    logic [63:0] z;
    z = v + 64'h9e3779b97f4a7c15;
    z = (z ^ (z >> 30)) * 64'hbf58476d1ce4e5b9;
    z = (z ^ (z >> 27)) * 64'h94d049bb133111eb;
    return z ^ (z >> 31);
  endfunction

  function automatic logic [63:0] hundredths_fx(input logic [63:0] h);
    return ((h << PROB_FRAC_BITS) + 64'd50) / 64'd100;
  endfunction

  // gate range in hundredths, as lo and hi packed {lo, hi}
  function automatic logic [15:0] range_h(input logic [FACT_W-1:0] cnt,
                                          input logic [FACT_W-1:0] f);
    if (cnt == 3'd2) begin
      return (f == 3'd1) ? {8'd10, 8'd45} : {8'd55, 8'd95};
    end else if (cnt == 3'd3) begin
      case (f)
        3'd1: return {8'd5, 8'd30};
        3'd2: return {8'd35, 8'd90};
        default: return {8'd15, 8'd55};
      endcase
    end else begin
      case (f)
        3'd2: return {8'd45, 8'd95};
        3'd3: return {8'd12, 8'd45};
        3'd4: return {8'd5, 8'd22};
        default: return {8'd2, 8'd18};
      endcase
    end
  endfunction

  function automatic logic [63:0] gate_of(input logic [63:0] src, input logic [63:0] dst,
                                          input logic [FACT_W-1:0] f);
    logic [15:0]  rh;
    logic [63:0]  lo, hi, x;
    logic [127:0] prod;
    rh = range_h(count_q, f);
    lo = hundredths_fx({56'd0, rh[15:8]});
    hi = hundredths_fx({56'd0, rh[7:0]});
    x = splitmix(seed_q ^ 64'h243f6a8885a308d3);
    x = splitmix(x ^ src);
    x = splitmix(x ^ dst);
    x = splitmix(x ^ {61'd0, f});
    prod = {64'd0, hi - lo} * {64'd0, x >> 11};
    return lo + prod[116:53];
  endfunction

  task automatic predict_edge(input logic [159:0] d);
    logic [63:0]       deg, p;
    logic [FACT_W-1:0] n;
    factor_prob_t      e;
    deg = {32'd0, d[159:128]};
    n = (count_q > 3'(MAX_FACTORS)) ? 3'(MAX_FACTORS) : count_q;
    if (deg != 0) begin
      for (int f = 1; f <= n; f++) begin
        if (gated_q) p = gate_of(d[63:0], d[127:64], 3'(f)) / deg;
        else p = (64'd1 << PROB_FRAC_BITS) / deg;
        e.factor = 3'(f);
        e.prob = p[PROB_W-1:0];
        e.last = (f == n);
        prob_queue = {prob_queue, e};
      end
    end
  endtask

  always @(posedge clk) begin
    factor_prob_t e;
    if (rst) begin
      gated_q <= 1'b0;
      count_q <= 3'd2;
      seed_q <= '0;
      prob_queue.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (prob_queue.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result %h last %b", m_tdata, m_tlast);
        end else begin
          e = prob_queue.pop_front();
          if (m_tdata[2:0] !== e.factor || m_tdata[35:3] !== e.prob ||
              m_tlast !== e.last) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch: exp factor %0d prob %h last %b, got %0d %h %b",
                       e.factor, e.prob, e.last, m_tdata[2:0], m_tdata[35:3], m_tlast);
          end
        end
      end
      // predict after popping so a same-edge request queues behind older results
      if (s_tvalid && s_tready) predict_edge(s_tdata);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GATED: gated_q <= cfg_data[0];
          CFG_COUNT: count_q <= cfg_data[FACT_W-1:0];
          CFG_SEED:  seed_q <= cfg_data;
          default: ;
        endcase
      end
      pending <= prob_queue.size();
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
// testbench top: edge stimulus, result back-pressure, verdict
`timescale 1ns / 1ps
module tb;
  import khegp_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [159:0]          s_tdata = '0;    // source_key, dest_key, in_degree
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [39:0]           m_tdata;         // factor_number, probability, zero pad
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    errors;
  int                    pending;
  int                    cycles = 0;
  logic                  edge_taken = 1'b0;
  logic                  cfg_taken = 1'b0;
  logic                  long_hold = 1'b0;

  localparam int LIMIT = 400000;
  localparam int DRAIN = 80;     // pipeline is about 57 deep

  keyed_hash_edge_gate_probability u_top (.*);

  khegp_checker u_chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // handshakes seen at the edge, read a moment later by the drivers
  always @(posedge clk) begin
    edge_taken <= s_tvalid && s_tready;
    cfg_taken <= cfg_valid && cfg_ready;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // receiver: random stalls, or one long hold-off when asked
  always begin
    int n;
    @(negedge clk);
    if (long_hold) begin
      m_tready = 1'b0;
      repeat (300) @(negedge clk);
      long_hold = 1'b0;
    end else begin
      n = gap_len();
      if (n > 0) begin
        m_tready = 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        m_tready = 1'b1;
        repeat ($urandom_range(0, 12)) @(negedge clk);
      end
    end
  end

  task automatic send_edge(input logic [63:0] src, input logic [63:0] dst,
                           input logic [31:0] deg, input bit no_gap);
    int n;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = {deg, dst, src};
    forever begin
      @(posedge clk);
      #1;
      if (edge_taken) break;
    end
    n = no_gap ? 0 : gap_len();
    if (n > 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    s_tvalid = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    forever begin
      @(posedge clk);
      #1;
      if (cfg_taken) break;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // sender pause until every expected result is back, then let the pipe empty
  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] rand_deg();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hffffffff;
      3, 4, 5: return $urandom_range(2, 40);
      default: return $urandom;
    endcase
  endfunction

  task automatic directed_edges();
    send_edge(64'd0, 64'd0, 32'd1, 1'b0);
    send_edge('1, '1, 32'hffffffff, 1'b0);
    send_edge(64'd0, '1, 32'd0, 1'b0);             // zero in-degree: nothing out
    send_edge('1, 64'd0, 32'd2, 1'b0);
    send_edge(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 32'd3, 1'b0);
  endtask

  // gated, count, seed of each phase; counts cover zero, one, four and saturation
  logic [2:0]  ph_count[12] = '{3'd2, 3'd2, 3'd3, 3'd5, 3'd4, 3'd1, 3'd0,
                                 3'd7, 3'd6, 3'd5, 3'd3, 3'd2};
  logic        ph_gated[12] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
                                 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};

  initial begin
    logic [63:0] seed;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // reset settings: uniform, two factors
    directed_edges();
    drain();

    for (int p = 0; p < 12; p++) begin
      if (p == 1) seed = '0;
      else if (p == 2) seed = '1;
      else seed = rand64();
      write_reg(CFG_GATED, {63'd0, ph_gated[p]});
      write_reg(CFG_COUNT, {61'd0, ph_count[p]});
      write_reg(CFG_SEED, seed);
      if (p == 4) write_reg(2'd3, rand64());      // unmapped index, ignored
      if (p < 4) directed_edges();
      if (p == 3) long_hold = 1'b1;              // block fills and stalls its input
      for (int i = 0; i < 24; i++) begin
        send_edge(rand64(), rand64(), rand_deg(), p == 3 && i < 20);
      end
      drain();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
